// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the duty cycler.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define VPDC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: %m");

// Check a property at every edge, reset included.
`define VPDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: %m");

`endif

// ===== design/vpdc_pkg.sv =====
// Package of the valve and pump duty cycler: widths, codes, run record type.
// No dependencies; every other design file but assert_macros.svh imports it.
`timescale 1ns / 1ps
`default_nettype none

package vpdc_pkg;

    localparam int VALVE_COUNT  = 4;
    localparam int VALVE_W      = 3;
    localparam int OPTION_W     = 4;
    localparam int TOKEN_W      = 4;
    localparam int VALVES_W     = 4;
    localparam int MARKS_W      = VALVES_W + 1;
    localparam int TPS_W        = 7;
    localparam int CNT_W        = 16;
    localparam int THR_W        = OPTION_W + TPS_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int RUN_MAX      = 3;
    localparam int RUN_CNT_W    = 2;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [TOKEN_W-1:0]  TOKEN_RESET   = 4'd0;
    localparam logic [TOKEN_W-1:0]  TOKEN_PUMP    = 4'd9;
    localparam logic [OPTION_W-1:0] CYCLE_SECONDS = 4'd10;
    localparam logic [TPS_W-1:0]    TPS_RESET     = 7'd10;
    localparam logic [CNT_W-1:0]    WDOG_RESET    = 16'd30;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPS  = 1'b0,
        CFG_WDOG = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [RUN_CNT_W-1:0]              n;
        logic [RUN_MAX-1:0][TOKEN_W-1:0]   tok;
        logic [RUN_MAX-1:0]                pump;
        logic [RUN_MAX-1:0][VALVES_W-1:0]  vlv;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// ===== design/vpdc_in_if.sv =====
// Input channel of the duty cycler: command or tick requests.
// Depends on vpdc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vpdc_in_if import vpdc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [VALVE_W-1:0]  valve;
    logic [OPTION_W-1:0] option;

    modport source (output valid, output operation, output valve, output option,
                    input ready);
    modport sink   (input valid, input operation, input valve, input option,
                    output ready);
endinterface

`default_nettype wire

// ===== design/vpdc_out_if.sv =====
// Output channel of the duty cycler: one token request per transfer.
// Depends on vpdc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vpdc_out_if import vpdc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TOKEN_W-1:0]  token;
    logic                last;
    logic                pump_on;
    logic [VALVES_W-1:0] valves_open;

    modport source (output valid, output token, output last, output pump_on,
                    output valves_open, input ready);
    modport sink   (input valid, input token, input last, input pump_on,
                    input valves_open, output ready);
endinterface

`default_nettype wire

// ===== design/vpdc_fifo.sv =====
// Short queue of token runs between the front and back stages.
// Depends on vpdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpdc_fifo import vpdc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_run   i_run,
    input  wire logic   i_pop,
    output t_run        o_head,
    output t_qstat      o_stat
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_run           r_mem [QUEUE_DEPTH];
    logic [PTR_W:0] r_wptr;
    logic [PTR_W:0] r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr[PTR_W-1:0]] <= i_run;
        end
    end

    assign o_head       = r_mem[r_rptr[PTR_W-1:0]];
    assign o_stat.empty = (r_wptr == r_rptr);
    assign o_stat.full  = (r_wptr[PTR_W] != r_rptr[PTR_W]) &&
                          (r_wptr[PTR_W-1:0] == r_rptr[PTR_W-1:0]);
endmodule

`default_nettype wire

// ===== design/vpdc_front.sv =====
// Front stage: accepts commands and ticks, keeps the valve state and
// builds each item's token run. Depends on vpdc_pkg and vpdc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module vpdc_front import vpdc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    vpdc_in_if.sink                    i_cmd,
    input  wire t_qstat                i_qstat,
    output logic                       o_push,
    output t_run                       o_run
);
    logic [TPS_W-1:0]    r_tps;
    logic [CNT_W-1:0]    r_wdog;
    logic                r_started;
    logic [VALVE_W-1:0]  r_held_valve;
    logic [OPTION_W-1:0] r_held_option;
    logic [MARKS_W-1:0]  r_marks;
    logic [CNT_W-1:0]    r_tsc_cmd;
    logic [CNT_W-1:0]    r_tsc_ctl;

    logic                n_started;
    logic [VALVE_W-1:0]  n_held_valve;
    logic [OPTION_W-1:0] n_held_option;
    logic [MARKS_W-1:0]  n_marks;
    logic [CNT_W-1:0]    n_tsc_cmd;
    logic [CNT_W-1:0]    n_tsc_ctl;

    logic                accept;
    logic [OPTION_W-1:0] secs;
    logic [THR_W-1:0]    thr;
    logic [CNT_W-1:0]    ctl_inc;
    logic [CNT_W-1:0]    cmd_inc;

    function automatic logic [MARKS_W-1:0] f_mask(logic [VALVE_W-1:0] v);
        logic [MARKS_W-1:0] m;
        m    = MARKS_W'(1) << v;
        m[0] = 1'b0;
        return m;
    endfunction

    function automatic logic [TOKEN_W-1:0] f_close_tok(logic [VALVE_W-1:0] v);
        return TOKEN_W'({v, 1'b0});
    endfunction

    function automatic logic [TOKEN_W-1:0] f_open_tok(logic [VALVE_W-1:0] v);
        return TOKEN_W'({v, 1'b0}) - TOKEN_W'(1);
    endfunction

    function automatic t_run f_push(t_run run, logic [TOKEN_W-1:0] tok,
                                    logic [MARKS_W-1:0] marks);
        t_run r;
        r             = run;
        r.tok[r.n]    = tok;
        r.pump[r.n]   = marks[0];
        r.vlv[r.n]    = marks[MARKS_W-1:1];
        r.n           = r.n + RUN_CNT_W'(1);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_sat_inc(logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + CNT_W'(1);
    endfunction

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !i_qstat.full;

    assign secs    = r_marks[0] ? (CYCLE_SECONDS - r_held_option) : r_held_option;
    assign thr     = THR_W'(secs) * THR_W'(r_tps);
    assign ctl_inc = f_sat_inc(r_tsc_ctl);
    assign cmd_inc = f_sat_inc(r_tsc_cmd);

    always_comb begin
        logic opening;
        logic [MARKS_W-1:0] m;
        t_run run;

        opening       = (i_cmd.option != CYCLE_SECONDS) && (i_cmd.valve != '0);
        m             = r_marks;
        run           = '0;
        n_started     = r_started;
        n_held_valve  = r_held_valve;
        n_held_option = r_held_option;
        n_tsc_cmd     = r_tsc_cmd;
        n_tsc_ctl     = r_tsc_ctl;

        if (i_cmd.operation == OP_COMMAND) begin
            if ((i_cmd.valve <= VALVE_W'(VALVE_COUNT)) &&
                    (i_cmd.option <= CYCLE_SECONDS)) begin
                n_tsc_cmd = '0;
                if (!(r_started && (i_cmd.valve == r_held_valve) &&
                        (i_cmd.option == r_held_option))) begin
                    if (!r_started) begin
                        if (opening) begin
                            m   = '0;
                            run = f_push(run, TOKEN_RESET, m);
                            m   = m | f_mask(i_cmd.valve);
                            run = f_push(run, f_open_tok(i_cmd.valve), m);
                            m[0] = ~m[0];
                            run = f_push(run, TOKEN_PUMP, m);
                            n_started     = 1'b1;
                            n_held_valve  = i_cmd.valve;
                            n_held_option = i_cmd.option;
                            n_tsc_ctl     = '0;
                        end
                    end else begin
                        if (r_held_valve == '0) begin
                            m = '0;
                        end else begin
                            m = m & ~f_mask(r_held_valve);
                        end
                        run = f_push(run, f_close_tok(r_held_valve), m);
                        if (opening) begin
                            m   = m | f_mask(i_cmd.valve);
                            run = f_push(run, f_open_tok(i_cmd.valve), m);
                            if (!m[0]) begin
                                m[0] = 1'b1;
                                run  = f_push(run, TOKEN_PUMP, m);
                            end
                        end else if (m[0]) begin
                            m[0] = 1'b0;
                            run  = f_push(run, TOKEN_PUMP, m);
                        end
                        n_held_valve  = i_cmd.valve;
                        n_held_option = i_cmd.option;
                        n_tsc_ctl     = '0;
                    end
                end
            end
        end else if (r_started) begin
            n_tsc_cmd = cmd_inc;
            n_tsc_ctl = ctl_inc;
            if (cmd_inc > r_wdog) begin
                m         = '0;
                run       = f_push(run, TOKEN_RESET, m);
                n_tsc_ctl = '0;
            end else if (r_held_valve != '0) begin
                if (m[0]) begin
                    if ((r_held_option != '0) && (ctl_inc >= CNT_W'(thr))) begin
                        m    = m & ~f_mask(r_held_valve);
                        run  = f_push(run, f_close_tok(r_held_valve), m);
                        m[0] = 1'b0;
                        run  = f_push(run, TOKEN_PUMP, m);
                        n_tsc_ctl = '0;
                    end
                end else begin
                    if ((r_held_option != CYCLE_SECONDS) &&
                            (ctl_inc >= CNT_W'(thr))) begin
                        m    = m | f_mask(r_held_valve);
                        run  = f_push(run, f_open_tok(r_held_valve), m);
                        m[0] = 1'b1;
                        run  = f_push(run, TOKEN_PUMP, m);
                        n_tsc_ctl = '0;
                    end
                end
            end
        end

        n_marks = m;
        o_run   = run;
        o_push  = accept && (run.n != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps         <= TPS_RESET;
            r_wdog        <= WDOG_RESET;
            r_started     <= 1'b0;
            r_held_valve  <= '0;
            r_held_option <= '0;
            r_marks       <= '0;
            r_tsc_cmd     <= '0;
            r_tsc_ctl     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TPS:  r_tps  <= i_cfg_data[TPS_W-1:0];
                    CFG_WDOG: r_wdog <= i_cfg_data[CNT_W-1:0];
                    default:  r_tps  <= r_tps;
                endcase
            end
            if (accept) begin
                r_started     <= n_started;
                r_held_valve  <= n_held_valve;
                r_held_option <= n_held_option;
                r_marks       <= n_marks;
                r_tsc_cmd     <= n_tsc_cmd;
                r_tsc_ctl     <= n_tsc_ctl;
            end
        end
    end
endmodule

`default_nettype wire

// ===== design/vpdc_back.sv =====
// Back stage: walks the queued runs and sends one token per cycle while o_tok
// is ready, through the output register. Depends on vpdc_pkg and vpdc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module vpdc_back import vpdc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_run   i_head,
    input  wire t_qstat i_qstat,
    output logic        o_pop,
    vpdc_out_if.source  o_tok
);
    logic [RUN_CNT_W-1:0] r_idx;
    logic                 r_valid;
    logic [TOKEN_W-1:0]   r_token;
    logic                 r_last;
    logic                 r_pump;
    logic [VALVES_W-1:0]  r_vlv;

    logic                 load;
    logic                 at_end;

    assign load   = !i_qstat.empty && (!r_valid || o_tok.ready);
    assign at_end = (r_idx == (i_head.n - RUN_CNT_W'(1)));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + RUN_CNT_W'(1);
            end else if (o_tok.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= i_head.tok[r_idx];
            r_last  <= at_end;
            r_pump  <= i_head.pump[r_idx];
            r_vlv   <= i_head.vlv[r_idx];
        end
    end

    assign o_tok.valid       = r_valid;
    assign o_tok.token       = r_token;
    assign o_tok.last        = r_last;
    assign o_tok.pump_on     = r_pump;
    assign o_tok.valves_open = r_vlv;
endmodule

`default_nettype wire

// ===== design/valve_pump_duty_cycler.sv =====
// Top level of the valve and pump duty cycler: front, queue and back.
// Depends on vpdc_pkg, vpdc_in_if, vpdc_out_if and the three stages.
//
// Use:
//   i_cmd carries requests, each a command (valve, option) or a time tick.
//   o_tok returns zero to three token requests per input request, the
//   final one flagged by last, each with the pump and valve marks after it.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) set ticks per
//   second and the watchdog limit; write them only while the block is idle.
// Timing:
//   The front takes one request per cycle while the four-entry run queue
//   has room; each non-empty run goes into the queue, and its tokens pass
//   through the back stage's output register before o_tok takes them.
//   The back sends one token per cycle while o_tok is ready, so runs of
//   several tokens can fill the queue and then hold off the front.
// Reset:
//   Synchronous, active low; clears the queue, the output valid flag, the
//   valve state and both tick counters, and loads the register defaults.
// Stall:
//   A held o_tok keeps its token; the queue fills, then i_cmd.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module valve_pump_duty_cycler import vpdc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    vpdc_in_if.sink                    i_cmd,
    vpdc_out_if.source                 o_tok
);
    logic   push;
    logic   pop;
    t_run   run;
    t_run   head;
    t_qstat qstat;

    vpdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_run      (run)
    );

    vpdc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    vpdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );
endmodule

`default_nettype wire

// ===== design/vpdc_chk.sv =====
// Port-level checker of the duty cycler and its bind to the top level.
// Depends on vpdc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vpdc_chk import vpdc_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [TOKEN_W-1:0]  i_out_token,
    input wire logic                i_out_last,
    input wire logic                i_out_pump,
    input wire logic [VALVES_W-1:0] i_out_valves
);
    `VPDC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid)
    `VPDC_ASSERT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_token) && $stable(i_out_last))
    `VPDC_ASSERT(a_reset_tok_clears, i_clk, i_rst_n, i_out_valid && (i_out_token == TOKEN_RESET) |-> !i_out_pump && (i_out_valves == '0))
    `VPDC_ASSERT(a_pump_tok_last, i_clk, i_rst_n, i_out_valid && (i_out_token == TOKEN_PUMP) |-> i_out_last)
endmodule

bind valve_pump_duty_cycler vpdc_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_tok.valid),
    .i_out_ready  (o_tok.ready),
    .i_out_token  (o_tok.token),
    .i_out_last   (o_tok.last),
    .i_out_pump   (o_tok.pump_on),
    .i_out_valves (o_tok.valves_open)
);

`default_nettype wire

// ===== test/valve_pump_duty_cycler_tb.sv =====
`timescale 1ns / 1ps
// Testbench for valve_pump_duty_cycler: a directed table and random phases over
// several register settings, two of them, the last included, without idling, all checked per token.
// Depends on vpdc_pkg, vpdc_in_if, vpdc_out_if and the design top level.

module valve_pump_duty_cycler_tb;
    import vpdc_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_ITEMS     = 96;

    typedef struct packed {
        logic [TOKEN_W-1:0]  token;
        logic                last;
        logic                pump_on;
        logic [VALVES_W-1:0] valves_open;
    } t_token;

    typedef struct packed {
        t_op                      op;
        logic [VALVE_W-1:0]       valve;
        logic [OPTION_W-1:0]      option;
        logic                     typed;
        logic [1:0]               count;
        t_token [0:RUN_MAX-1]     toks;
    } t_step;

    localparam t_token NONE = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vpdc_in_if  cmd_bus ();
    vpdc_out_if tok_bus ();

    valve_pump_duty_cycler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_tok      (tok_bus)
    );

    // valve and pump state as the block should hold it
    logic [TPS_W-1:0]    tps_reg;
    logic [CNT_W-1:0]    wdog_reg;
    bit                  started;
    logic [VALVE_W-1:0]  held_valve;
    logic [OPTION_W-1:0] held_option;
    logic [MARKS_W-1:0]  marks;
    logic [CNT_W-1:0]    since_cmd;
    logic [CNT_W-1:0]    since_ctrl;

    t_token run_tokens[$];
    t_token due_tokens[$];
    t_step  steps[$];
    t_token got_token;
    t_token want_token;
    int     errors = 0;
    bit     idle_en = 1'b1;
    bit     hold_off_pending = 1'b0;
    int     hold_left = 0;
    int     rx_gap = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_token tk(logic [TOKEN_W-1:0] tok, logic last, logic pump,
                                  logic [VALVES_W-1:0] vo);
        return {tok, last, pump, vo};
    endfunction

    function automatic t_step mk(t_op op, int v, int opt, bit typed, int count,
                                 t_token t0, t_token t1, t_token t2);
        t_step s;
        s.op      = op;
        s.valve   = VALVE_W'(v);
        s.option  = OPTION_W'(opt);
        s.typed   = typed;
        s.count   = 2'(count);
        s.toks[0] = t0;
        s.toks[1] = t1;
        s.toks[2] = t2;
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    task automatic emit(input logic [TOKEN_W-1:0] tok);
        if (tok == TOKEN_PUMP)
            marks[0] = ~marks[0];
        run_tokens.push_back({tok, 1'b0, marks[0], marks[MARKS_W-1:1]});
    endtask

    task automatic plan_tokens(input t_op op, input logic [VALVE_W-1:0] v,
                               input logic [OPTION_W-1:0] opt);
        logic   opening;
        int     thr;
        t_token tail;
        run_tokens.delete();
        if (op == OP_COMMAND) begin
            if (v <= VALVE_COUNT && opt <= CYCLE_SECONDS) begin
                since_cmd = '0;
                if (!(started && v == held_valve && opt == held_option)) begin
                    opening = (opt != CYCLE_SECONDS) && (v != 0);
                    if (!started) begin
                        if (opening) begin
                            marks = '0;
                            emit(TOKEN_RESET);
                            marks[v] = 1'b1;
                            emit(TOKEN_W'(2 * v - 1));
                            emit(TOKEN_PUMP);
                            started     = 1'b1;
                            held_valve  = v;
                            held_option = opt;
                            since_ctrl  = '0;
                        end
                    end else begin
                        if (held_valve == 0)
                            marks = '0;
                        else
                            marks[held_valve] = 1'b0;
                        emit(TOKEN_W'(2 * held_valve));
                        if (opening) begin
                            marks[v] = 1'b1;
                            emit(TOKEN_W'(2 * v - 1));
                            if (!marks[0])
                                emit(TOKEN_PUMP);
                        end else if (marks[0]) begin
                            emit(TOKEN_PUMP);
                        end
                        held_valve  = v;
                        held_option = opt;
                        since_ctrl  = '0;
                    end
                end
            end
        end else if (started) begin
            since_cmd  = sat_inc(since_cmd);
            since_ctrl = sat_inc(since_ctrl);
            if (since_cmd > wdog_reg) begin
                marks = '0;
                emit(TOKEN_RESET);
                since_ctrl = '0;
            end else if (held_valve != 0) begin
                if (marks[0]) begin
                    thr = int'(CYCLE_SECONDS - held_option) * int'(tps_reg);
                    if (held_option != 0 && int'(since_ctrl) >= thr) begin
                        marks[held_valve] = 1'b0;
                        emit(TOKEN_W'(2 * held_valve));
                        emit(TOKEN_PUMP);
                        since_ctrl = '0;
                    end
                end else begin
                    thr = int'(held_option) * int'(tps_reg);
                    if (held_option != CYCLE_SECONDS && int'(since_ctrl) >= thr) begin
                        marks[held_valve] = 1'b1;
                        emit(TOKEN_W'(2 * held_valve - 1));
                        emit(TOKEN_PUMP);
                        since_ctrl = '0;
                    end
                end
            end
        end
        if (run_tokens.size() > 0) begin
            tail = run_tokens.pop_back();
            tail.last = 1'b1;
            run_tokens.push_back(tail);
        end
    endtask

    task automatic send_req(input t_op op, input logic [VALVE_W-1:0] v,
                            input logic [OPTION_W-1:0] opt, input bit use_plan);
        int gap;
        gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.valve     <= v;
        cmd_bus.option    <= opt;
        @(posedge i_clk);
        while (!cmd_bus.ready)
            @(posedge i_clk);
        plan_tokens(op, v, opt);
        if (use_plan)
            foreach (run_tokens[k])
                due_tokens.push_back(run_tokens[k]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (due_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TPS)
            tps_reg = data[TPS_W-1:0];
        else
            wdog_reg = data;
    endtask

    task automatic run_phase(input int tps, input int wdog, input int cmd_pct,
                             input bit idle, input bit squeeze);
        int                  r;
        t_op                 op;
        logic [VALVE_W-1:0]  v;
        logic [OPTION_W-1:0] opt;
        drain();
        idle_en = idle;
        write_reg(CFG_TPS, CFG_DATA_W'(tps));
        write_reg(CFG_WDOG, CFG_DATA_W'(wdog));
        if (squeeze)
            hold_off_pending = 1'b1;
        repeat (PHASE_ITEMS) begin
            r   = $urandom_range(0, 99);
            op  = OP_TICK;
            v   = VALVE_W'($urandom_range(0, 7));
            opt = OPTION_W'($urandom_range(0, 15));
            if (r < 10) begin
                op = t_op'($urandom_range(0, 1));
            end else if (r < 10 + cmd_pct) begin
                op = OP_COMMAND;
                if ($urandom_range(0, 6) == 0) begin
                    v   = held_valve;
                    opt = held_option;
                end else begin
                    v   = VALVE_W'($urandom_range(0, VALVE_COUNT));
                    opt = OPTION_W'($urandom_range(0, CYCLE_SECONDS));
                end
            end
            send_req(op, v, opt, 1'b1);
        end
    endtask

    // receiver: random ready bursts plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            tok_bus.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            tok_bus.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 13);
            tok_bus.ready <= 1'b0;
        end else begin
            tok_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tok_bus.valid && tok_bus.ready) begin
            got_token = {tok_bus.token, tok_bus.last, tok_bus.pump_on, tok_bus.valves_open};
            if (due_tokens.size() == 0) begin
                $display("%0t: unexpected token %0d last %0b pump %0b valves %b",
                         $time, got_token.token, got_token.last, got_token.pump_on,
                         got_token.valves_open);
                errors++;
            end else begin
                want_token = due_tokens.pop_front();
                if (got_token !== want_token) begin
                    $display("%0t: expected token %0d last %0b pump %0b valves %b,",
                             $time, want_token.token, want_token.last,
                             want_token.pump_on, want_token.valves_open);
                    $display("%0t:      got token %0d last %0b pump %0b valves %b",
                             $time, got_token.token, got_token.last,
                             got_token.pump_on, got_token.valves_open);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_TPS;
        i_cfg_data        = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.operation = OP_COMMAND;
        cmd_bus.valve     = '0;
        cmd_bus.option    = '0;
        tok_bus.ready     = 1'b0;
        tps_reg     = TPS_RESET;
        wdog_reg    = WDOG_RESET;
        started     = 1'b0;
        held_valve  = '0;
        held_option = '0;
        marks       = '0;
        since_cmd   = '0;
        since_ctrl  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_TPS, CFG_DATA_W'(1));
        write_reg(CFG_WDOG, CFG_DATA_W'(6));

        steps.push_back(mk(OP_TICK,    0,  0, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 7,  3, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 2, 15, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 4, 11, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 0,  5, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 3, 10, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 1,  0, 1, 3, tk(TOKEN_RESET, 0, 0, 4'b0000),
                           tk(4'd1, 0, 0, 4'b0001), tk(TOKEN_PUMP, 1, 1, 4'b0001)));
        steps.push_back(mk(OP_COMMAND, 1,  0, 1, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 4, 10, 1, 2, tk(4'd2, 0, 1, 4'b0000),
                           tk(TOKEN_PUMP, 1, 0, 4'b0000), NONE));
        steps.push_back(mk(OP_COMMAND, 4,  5, 1, 3, tk(4'd8, 0, 0, 4'b0000),
                           tk(4'd7, 0, 0, 4'b1000), tk(TOKEN_PUMP, 1, 1, 4'b1000)));
        repeat (7)
            steps.push_back(mk(OP_TICK, 7, 15, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 0,  0, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 2,  0, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_TICK,    0,  0, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 4, 10, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 0, 10, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 1,  1, 0, 0, NONE, NONE, NONE));
        steps.push_back(mk(OP_COMMAND, 7, 15, 1, 0, NONE, NONE, NONE));

        foreach (steps[i]) begin
            send_req(steps[i].op, steps[i].valve, steps[i].option, !steps[i].typed);
            if (steps[i].typed)
                for (int k = 0; k < steps[i].count; k++)
                    due_tokens.push_back(steps[i].toks[k]);
        end

        run_phase(1,   20,    25, 1'b1, 1'b0);
        run_phase(2,   65535, 20, 1'b0, 1'b1);
        run_phase(3,   1,     30, 1'b1, 1'b0);
        run_phase(100, 40,    35, 1'b1, 1'b0);
        run_phase(7,   12,    25, 1'b0, 1'b0);
        drain();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/vpdc_pkg.sv
design/vpdc_in_if.sv
design/vpdc_out_if.sv
design/vpdc_fifo.sv
design/vpdc_front.sv
design/vpdc_back.sv
design/valve_pump_duty_cycler.sv
design/vpdc_chk.sv
test/valve_pump_duty_cycler_tb.sv
